// ===== hdl/tccr_pkg.sv =====
// Shared types, constants and the fixed 16-color table for the cell color resolver.
// No dependencies; imported by every module of the block.
package tccr_pkg;

  typedef logic [23:0] rgb_t;

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  localparam logic [1:0] REG_DEFAULT_FG = 2'd0;
  localparam logic [1:0] REG_DEFAULT_BG = 2'd1;
  localparam logic [1:0] REG_SCREEN_REV = 2'd2;

  localparam rgb_t DEFAULT_FG_RESET = 24'hD0D0D0;
  localparam rgb_t DEFAULT_BG_RESET = 24'h1C1C1C;

  localparam logic [7:0] CUBE_BASE = 8'd16;
  localparam logic [7:0] GRAY_BASE = 8'd232;

  localparam rgb_t BASE16 [16] = '{
    24'h1C1C1C, 24'hCC3333, 24'h33AA55, 24'hCCAA33,
    24'h3377DD, 24'hAA55CC, 24'h33AAAA, 24'hD0D0D0,
    24'h555555, 24'hFF5555, 24'h55DD77, 24'hFFDD55,
    24'h5599FF, 24'hDD77FF, 24'h55DDDD, 24'hFFFFFF
  };

  localparam logic [7:0] CUBE_STEPS [6] = '{
    8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
  };

  typedef struct packed {
    logic dim;
    logic rev;
    logic hidden;
  } attr_t;

endpackage

// ===== hdl/terminal_cell_color_resolver_top.sv =====
// Each accepted transaction passes the lane stage register, then the output register.
// Throughput: one transaction per cycle unless out_tready stalls; the foreground and
// background lanes resolve in parallel and the merge logic feeds the output register.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the
// default colors 0xD0D0D0 / 0x1C1C1C with screen reverse off.
// Top level; depends on tccr_pkg, tccr_lane and tccr_merge.
module terminal_cell_color_resolver_top
  import tccr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fg_red_or_index, fg_green, fg_blue, bg_red_or_index, bg_green, bg_blue
  input  logic [47:0] in_tdata,
  // fg_kind[1:0], bg_kind[3:2], bold_flag, dim_flag, reverse_flag, hidden_flag
  input  logic [7:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_fg_red, out_fg_green, out_fg_blue, out_bg_red, out_bg_green, out_bg_blue
  output logic [47:0] out_tdata
);

  rgb_t  dflt_fg_r;
  rgb_t  dflt_bg_r;
  logic  scr_rev_r;

  rgb_t  fg_lane;
  rgb_t  bg_lane;
  rgb_t  fg_mrg;
  rgb_t  bg_mrg;

  logic  s1_v_r;
  rgb_t  s1_fg_r;
  rgb_t  s1_bg_r;
  attr_t s1_attr_r;
  attr_t attr_nxt;

  logic  out_v_r;
  logic [47:0] out_data_r;

  logic  s2_ld;
  logic  s1_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_fg_r <= DEFAULT_FG_RESET;
      dflt_bg_r <= DEFAULT_BG_RESET;
      scr_rev_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_FG: dflt_fg_r <= cfg_wdata;
        REG_DEFAULT_BG: dflt_bg_r <= cfg_wdata;
        REG_SCREEN_REV: scr_rev_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tccr_lane u_fg_lane (
    .kind         (in_tuser[1:0]),
    .red_or_index (in_tdata[7:0]),
    .green        (in_tdata[15:8]),
    .blue         (in_tdata[23:16]),
    .dflt         (dflt_fg_r),
    .brighten     (in_tuser[4]),
    .rgb          (fg_lane)
  );

  tccr_lane u_bg_lane (
    .kind         (in_tuser[3:2]),
    .red_or_index (in_tdata[31:24]),
    .green        (in_tdata[39:32]),
    .blue         (in_tdata[47:40]),
    .dflt         (dflt_bg_r),
    .brighten     (1'b0),
    .rgb          (bg_lane)
  );

  assign attr_nxt.dim    = in_tuser[5];
  assign attr_nxt.rev    = in_tuser[6] ^ scr_rev_r;
  assign attr_nxt.hidden = in_tuser[7];

  assign s2_ld     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s2_ld;
  assign s1_ld     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_fg_r   <= fg_lane;
      s1_bg_r   <= bg_lane;
      s1_attr_r <= attr_nxt;
    end
  end

  tccr_merge u_merge (
    .fg_in  (s1_fg_r),
    .bg_in  (s1_bg_r),
    .attr   (s1_attr_r),
    .fg_out (fg_mrg),
    .bg_out (bg_mrg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      out_data_r <= {bg_mrg[7:0], bg_mrg[15:8], bg_mrg[23:16],
                     fg_mrg[7:0], fg_mrg[15:8], fg_mrg[23:16]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ld |=> s1_v_r)
    else $error("accepted transaction did not enter the lane stage");

  a_s2_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ld |=> out_tvalid)
    else $error("merged result did not reach the output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled without a full pipeline");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> out_v_r)
    else $error("pending result dropped");

endmodule

// ===== hdl/tccr_lane.sv =====
// One color lane: resolves a default, palette or direct RGB color to 24-bit RGB.
// Depends on tccr_pkg for the palette tables and kind codes.
module tccr_lane
  import tccr_pkg::*;
(
  input  logic [1:0] kind,
  input  logic [7:0] red_or_index,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  rgb_t       dflt,
  input  logic       brighten,
  output rgb_t       rgb
);

  logic [7:0]  idx;
  logic [7:0]  cube;
  logic [15:0] prod36;
  logic [15:0] prod6;
  logic [2:0]  q36;
  logic [5:0]  q6;
  logic [5:0]  q6_rem;
  logic [7:0]  b_rem;
  logic [7:0]  gray_off;
  logic [7:0]  gray;
  rgb_t        pal;

  // Bold lifts the eight low palette entries to their bright counterparts.
  assign idx = (brighten && kind == KIND_PALETTE && red_or_index < 8'd8) ?
               (red_or_index | 8'd8) : red_or_index;

  // Cube digits via reciprocal multiplies, exact for offsets below 216.
  assign cube   = idx - CUBE_BASE;
  assign prod36 = 16'(cube) * 16'd57;
  assign prod6  = 16'(cube) * 16'd171;
  assign q36    = prod36[13:11];
  assign q6     = prod6[15:10];
  assign q6_rem = q6 - 6'(q36) * 6'd6;
  assign b_rem  = cube - 8'(q6) * 8'd6;

  assign gray_off = idx - GRAY_BASE;
  assign gray     = 8'd8 + gray_off * 8'd10;

  always_comb begin
    if (idx < CUBE_BASE) begin
      pal = BASE16[idx[3:0]];
    end else if (idx < GRAY_BASE) begin
      pal = {CUBE_STEPS[q36], CUBE_STEPS[q6_rem[2:0]], CUBE_STEPS[b_rem[2:0]]};
    end else begin
      pal = {gray, gray, gray};
    end
  end

  always_comb begin
    case (kind)
      KIND_PALETTE: rgb = pal;
      KIND_RGB:     rgb = {red_or_index, green, blue};
      default:      rgb = dflt;
    endcase
  end

endmodule

// ===== hdl/tccr_merge.sv =====
// Merge stage: applies dim, reverse and hidden to the two resolved lane colors.
// Depends on tccr_pkg for rgb_t and attr_t.
module tccr_merge
  import tccr_pkg::*;
(
  input  rgb_t  fg_in,
  input  rgb_t  bg_in,
  input  attr_t attr,
  output rgb_t  fg_out,
  output rgb_t  bg_out
);

  rgb_t fg_dim;
  rgb_t fg_sw;

  assign fg_dim = attr.dim ? ((fg_in >> 1) & 24'h7F7F7F) : fg_in;
  assign fg_sw  = attr.rev ? bg_in : fg_dim;
  assign bg_out = attr.rev ? fg_dim : bg_in;
  assign fg_out = attr.hidden ? bg_out : fg_sw;

endmodule
